// ===== src/q2e_pkg.sv =====
// Package for the quaternion to Euler angle converter: types, constants and the arctangent table.
package q2e_pkg;

   localparam int QW = 16;                 // component width, Q1.15
   localparam int OW = 16;                 // angle width, Q4.12
   localparam int CW = 40;                 // CORDIC vector width
   localparam int AW = 38;                 // angle accumulator width, scaled by 2^30
   localparam int SW = 64;                 // square root datapath width
   localparam int SQRT_STEPS = 32;         // one result bit per step
   localparam int SIDE_DEPTH = SQRT_STEPS + 3;
   localparam int DEF_CORDIC_STAGES = 16;

   localparam logic signed [AW-1:0] HALF_PI = 38'sd1686629713;
   localparam logic signed [32:0] TEST_LIMIT = 33'sd535822336;   // (0.5 - 1/1024) * 2^30

   typedef struct packed {
      logic signed [QW-1:0] quat_w;
      logic signed [QW-1:0] quat_x;
      logic signed [QW-1:0] quat_y;
      logic signed [QW-1:0] quat_z;
   } quat_type;

   typedef struct packed {
      logic signed [OW-1:0] roll_angle;
      logic signed [OW-1:0] pitch_angle;
      logic signed [OW-1:0] yaw_angle;
      logic                 gimbal_lock;
   } euler_type;

   // running remainder and root of the digit-by-digit square root
   typedef struct packed {
      logic [SW-1:0] rem;
      logic [SW-1:0] root;
   } sq_state_type;

   // vector and accumulated angle of one CORDIC lane
   typedef struct packed {
      logic signed [CW-1:0] xv;
      logic signed [CW-1:0] yv;
      logic signed [AW-1:0] ang;
   } cordic_state_type;

   // floor(atan(2^-i) * 2^30)
   function automatic logic signed [AW-1:0] atan_entry(input int unsigned idx);
      logic signed [AW-1:0] val;
      unique case (idx)
         0:  val = 38'sd843314856;
         1:  val = 38'sd497837829;
         2:  val = 38'sd263043836;
         3:  val = 38'sd133525158;
         4:  val = 38'sd67021686;
         5:  val = 38'sd33543515;
         6:  val = 38'sd16775850;
         7:  val = 38'sd8388437;
         8:  val = 38'sd4194282;
         9:  val = 38'sd2097149;
         10: val = 38'sd1048575;
         11: val = 38'sd524287;
         12: val = 38'sd262143;
         13: val = 38'sd131071;
         14: val = 38'sd65535;
         15: val = 38'sd32767;
         16: val = 38'sd16383;
         17: val = 38'sd8191;
         18: val = 38'sd4095;
         19: val = 38'sd2047;
         20: val = 38'sd1023;
         21: val = 38'sd511;
         22: val = 38'sd255;
         23: val = 38'sd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== src/q2e_sqrt_cell.sv =====
// One step of the pipelined integer square root: settles one bit of the root.
module q2e_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  enable,
   input  q2e_pkg::sq_state_type prev,
   output q2e_pkg::sq_state_type data
);

   localparam logic [q2e_pkg::SW-1:0] BIT = q2e_pkg::SW'(1) << (2 * STEP);

   q2e_pkg::sq_state_type data_ff, data_in;
   logic [q2e_pkg::SW-1:0] trial;

   // restoring step: subtract root + bit when it fits
   always_comb begin
      trial = prev.root + BIT;
      if (prev.rem >= trial) begin
         data_in.rem  = prev.rem - trial;
         data_in.root = (prev.root >> 1) + BIT;
      end else begin
         data_in.rem  = prev.rem;
         data_in.root = prev.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

// ===== src/q2e_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation with its own register.
module q2e_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                      clock,
   input  logic                      enable,
   input  q2e_pkg::cordic_state_type prev,
   output q2e_pkg::cordic_state_type data
);

   localparam logic signed [q2e_pkg::AW-1:0] ATAN = q2e_pkg::atan_entry(STEP);

   q2e_pkg::cordic_state_type data_ff, data_in;
   logic signed [q2e_pkg::CW-1:0] dx, dy;

   // rotate towards the x axis
   always_comb begin
      dx = prev.yv >>> STEP;
      dy = prev.xv >>> STEP;
      if (prev.yv > 0) begin
         data_in.xv  = prev.xv + dx;
         data_in.yv  = prev.yv - dy;
         data_in.ang = prev.ang + ATAN;
      end else begin
         data_in.xv  = prev.xv - dx;
         data_in.yv  = prev.yv + dy;
         data_in.ang = prev.ang - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

// ===== src/quaternion_to_euler.sv =====
// Top level of the quaternion to Euler angle (ZYX) converter.
//
// Input channel req_: one unit quaternion (w, x, y, z, Q1.15) per item.
// Result channel rsp_: roll, pitch, yaw in radians (Q4.12, saturated) and
// a gimbal lock flag, exactly one result item per input item, in order.
// Items are accepted when req_valid is high and req_stall low.
//
// From acceptance to rsp_valid an item passes the registers of products,
// sums and squaring, 32 square root steps (one root bit each), a quadrant
// stage, one register per CORDIC step and the output register. Throughput
// is one item per cycle while rsp_stall does not hold the pipeline; the
// three angles run in parallel CORDIC lanes.
//
// Reset clears all valid flags; no result is pending afterwards.
// The whole pipeline advances together: while a result waits with
// rsp_stall high, the pipeline holds and req_stall is raised. As soon as
// the result is taken a new item may enter in the same cycle.
module quaternion_to_euler #(
   parameter int CORDIC_STAGES = q2e_pkg::DEF_CORDIC_STAGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  q2e_pkg::quat_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output q2e_pkg::euler_type rsp_data
);

   localparam int CW = q2e_pkg::CW;
   localparam int AW = q2e_pkg::AW;
   localparam int SW = q2e_pkg::SW;
   localparam int SD = q2e_pkg::SIDE_DEPTH;
   localparam int NS = q2e_pkg::SQRT_STEPS;

   typedef struct packed {
      logic signed [31:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
      logic signed [15:0] w, x;
   } prod_type;

   typedef struct packed {
      logic                 valid;
      logic                 lock;
      logic                 pos;
      logic signed [CW-1:0] s;
      logic signed [CW-1:0] ry, rx, yy, yx;
   } side_type;

   typedef struct packed {
      logic valid;
      logic lock;
      logic pos;
      logic zr, zp, zy;
   } tag_type;

   logic advance;

   prod_type prod_ff, prod_in;
   logic     va_ff;
   side_type side_ff [SD];
   side_type side_in;
   logic [30:0] mag_ff, mag_in;
   logic [29:0] sq_hi_ff;
   logic [30:0] sq_mid_ff;
   logic [31:0] sq_lo_ff;
   q2e_pkg::sq_state_type sq_chain [NS+1];
   q2e_pkg::sq_state_type sq_start_in;
   q2e_pkg::cordic_state_type cr_chain [CORDIC_STAGES+1];
   q2e_pkg::cordic_state_type cp_chain [CORDIC_STAGES+1];
   q2e_pkg::cordic_state_type cy_chain [CORDIC_STAGES+1];
   q2e_pkg::cordic_state_type cr_in, cp_in, cy_in;
   tag_type tag_ff [CORDIC_STAGES+1];
   tag_type tag_in;
   logic zr_in, zp_in, zy_in;
   logic rsp_valid_ff;
   q2e_pkg::euler_type rsp_data_ff, rsp_data_in;

   // pipeline moves when the output register is free or being emptied
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // quadrant correction ahead of the CORDIC chain
   function automatic q2e_pkg::cordic_state_type prerot(input logic signed [CW-1:0] yv,
                                                        input logic signed [CW-1:0] xv);
      q2e_pkg::cordic_state_type st;
      if (xv < 0) begin
         if (yv >= 0) begin
            st.xv  = yv;
            st.yv  = -xv;
            st.ang = q2e_pkg::HALF_PI;
         end else begin
            st.xv  = -yv;
            st.yv  = xv;
            st.ang = -q2e_pkg::HALF_PI;
         end
      end else begin
         st.xv  = xv;
         st.yv  = yv;
         st.ang = '0;
      end
      return st;
   endfunction

   // round to Q4.12 and saturate
   function automatic logic signed [15:0] to_q412(input logic signed [AW:0] a);
      logic signed [AW:0] r;
      r = (a + (AW+1)'(131072)) >>> 18;
      if (r > (AW+1)'(32767)) begin
         return 16'sh7fff;
      end else if (r < -(AW+1)'(32768)) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

   // component products
   always_comb begin
      prod_in.ww = req_data.quat_w * req_data.quat_w;
      prod_in.xx = req_data.quat_x * req_data.quat_x;
      prod_in.yy = req_data.quat_y * req_data.quat_y;
      prod_in.zz = req_data.quat_z * req_data.quat_z;
      prod_in.wx = req_data.quat_w * req_data.quat_x;
      prod_in.wy = req_data.quat_w * req_data.quat_y;
      prod_in.wz = req_data.quat_w * req_data.quat_z;
      prod_in.xy = req_data.quat_x * req_data.quat_y;
      prod_in.xz = req_data.quat_x * req_data.quat_z;
      prod_in.yz = req_data.quat_y * req_data.quat_z;
      prod_in.w  = req_data.quat_w;
      prod_in.x  = req_data.quat_x;
   end

   // test term, branch choice and CORDIC operands
   always_comb begin
      logic signed [32:0] test;
      logic signed [33:0] s;
      logic signed [33:0] s_abs;
      test = 33'(prod_ff.wy) - 33'(prod_ff.xz);
      s    = 34'(test) <<< 1;
      s_abs = s[33] ? -s : s;
      mag_in        = s_abs[30:0];
      side_in.valid = va_ff;
      side_in.lock  = (test > q2e_pkg::TEST_LIMIT) || (test < -q2e_pkg::TEST_LIMIT);
      side_in.pos   = test > 33'sd0;
      side_in.s     = CW'(s);
      side_in.ry    = (CW'(prod_ff.yz) + CW'(prod_ff.wx)) <<< 1;
      side_in.rx    = CW'(prod_ff.ww) - CW'(prod_ff.xx) - CW'(prod_ff.yy) + CW'(prod_ff.zz);
      if (side_in.lock) begin
         side_in.yy = CW'(prod_ff.x) <<< 16;
         side_in.yx = CW'(prod_ff.w) <<< 16;
      end else begin
         side_in.yy = (CW'(prod_ff.xy) + CW'(prod_ff.wz)) <<< 1;
         side_in.yx = CW'(prod_ff.ww) + CW'(prod_ff.xx) - CW'(prod_ff.yy) - CW'(prod_ff.zz);
      end
   end

   // 1 - s^2 from the partial squares
   always_comb begin
      logic [SW-1:0] s2;
      s2 = (SW'(sq_hi_ff) << 32) + (SW'(sq_mid_ff) << 17) + SW'(sq_lo_ff);
      sq_start_in.rem  = (SW'(1) << 60) - s2;
      sq_start_in.root = '0;
   end

   // front stages and sideband delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         for (int i = 0; i < SD; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         va_ff   <= req_valid;
         prod_ff <= prod_in;
         side_ff[0] <= side_in;
         mag_ff     <= mag_in;
         sq_hi_ff   <= 30'(mag_ff[30:16] * mag_ff[30:16]);
         sq_mid_ff  <= 31'(mag_ff[30:16] * mag_ff[15:0]);
         sq_lo_ff   <= mag_ff[15:0] * mag_ff[15:0];
         sq_chain[0] <= sq_start_in;
         for (int i = 1; i < SD; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // square root chain
   for (genvar j = 0; j < NS; j++) begin : g_sqrt
      q2e_sqrt_cell #(.STEP(NS - 1 - j)) u_cell (
         .clock  (clock),
         .enable (advance),
         .prev   (sq_chain[j]),
         .data   (sq_chain[j+1])
      );
   end

   // quadrant stage for the three lanes
   always_comb begin
      side_type sd;
      logic signed [CW-1:0] c;
      sd = side_ff[SD-1];
      c  = CW'(sq_chain[NS].root);
      cr_in = prerot(sd.ry, sd.rx);
      cp_in = prerot(sd.s, c);
      cy_in = prerot(sd.yy, sd.yx);
      zr_in = (sd.ry == '0) && (sd.rx == '0);
      zp_in = (sd.s == '0) && (c == '0);
      zy_in = (sd.yy == '0) && (sd.yx == '0);
      tag_in = '{valid: sd.valid, lock: sd.lock, pos: sd.pos,
                 zr: zr_in, zp: zp_in, zy: zy_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STAGES; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         tag_ff[0]   <= tag_in;
         cr_chain[0] <= cr_in;
         cp_chain[0] <= cp_in;
         cy_chain[0] <= cy_in;
         for (int i = 1; i <= CORDIC_STAGES; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   // CORDIC lanes: roll, pitch, yaw
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      q2e_cordic_cell #(.STEP(i)) u_roll (
         .clock (clock), .enable (advance), .prev (cr_chain[i]), .data (cr_chain[i+1])
      );
      q2e_cordic_cell #(.STEP(i)) u_pitch (
         .clock (clock), .enable (advance), .prev (cp_chain[i]), .data (cp_chain[i+1])
      );
      q2e_cordic_cell #(.STEP(i)) u_yaw (
         .clock (clock), .enable (advance), .prev (cy_chain[i]), .data (cy_chain[i+1])
      );
   end

   // branch selection and rounding
   always_comb begin
      tag_type t;
      logic signed [AW:0] ar, ap, ay;
      t  = tag_ff[CORDIC_STAGES];
      ar = t.zr ? '0 : (AW+1)'(cr_chain[CORDIC_STAGES].ang);
      ap = t.zp ? '0 : (AW+1)'(cp_chain[CORDIC_STAGES].ang);
      ay = t.zy ? '0 : (AW+1)'(cy_chain[CORDIC_STAGES].ang);
      if (t.lock) begin
         ar = '0;
         ap = t.pos ? (AW+1)'(q2e_pkg::HALF_PI) : -(AW+1)'(q2e_pkg::HALF_PI);
         ay = t.pos ? -(ay <<< 1) : (ay <<< 1);
      end
      rsp_data_in.roll_angle  = to_q412(ar);
      rsp_data_in.pitch_angle = to_q412(ap);
      rsp_data_in.yaw_angle   = to_q412(ay);
      rsp_data_in.gimbal_lock = t.lock;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tag_ff[CORDIC_STAGES].valid;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== verif/tb_quaternion_to_euler.sv =====
// Testbench for the quaternion to Euler angle converter: predictor, scoreboard and stimulus.
module tb_quaternion_to_euler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 2000;
   localparam int LATENCY = 38 + q2e_pkg::DEF_CORDIC_STAGES;
   localparam int IDLE_LIMIT = 20000;
   localparam longint LOCK_LIMIT = 511 * 1048576;
   localparam longint ANG_HALF = 1686629713;
   localparam longint Q30_ONE = 1073741824;

   // arctangent table, floor(atan(2^-i) * 2^30)
   localparam longint ATAN_LUT [24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

   // vectoring CORDIC on exact integers, angle scaled by 2^30
   function automatic longint vector_angle(longint yin, longint xin);
      longint xv, yv, ang, tmp, dx, dy;
      xv = xin;
      yv = yin;
      ang = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         tmp = xv;
         if (yv >= 0) begin
            xv = yv; yv = -tmp; ang = ANG_HALF;
         end else begin
            xv = -yv; yv = tmp; ang = -ANG_HALF;
         end
      end
      for (int i = 0; i < q2e_pkg::DEF_CORDIC_STAGES && i < 24; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv > 0) begin
            xv += dx; yv -= dy; ang += ATAN_LUT[i];
         end else begin
            xv -= dx; yv += dy; ang -= ATAN_LUT[i];
         end
      end
      return ang;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [q2e_pkg::OW-1:0] round_q412(longint a);
      longint r;
      r = (a + 131072) >>> 18;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[q2e_pkg::OW-1:0];
   endfunction

   function automatic q2e_pkg::euler_type predict_euler(q2e_pkg::quat_type q);
      longint w, x, y, z, tst, s, c, roll, pitch, yaw, a;
      longint unsigned rem;
      q2e_pkg::euler_type e;
      w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
      tst = w * y - x * z;
      if (tst > LOCK_LIMIT || tst < -LOCK_LIMIT) begin
         a = vector_angle(x * 65536, w * 65536);
         yaw = (tst > 0) ? -2 * a : 2 * a;
         pitch = (tst > 0) ? ANG_HALF : -ANG_HALF;
         roll = 0;
         e.gimbal_lock = 1'b1;
      end else begin
         s = 2 * tst;
         rem = longint'(Q30_ONE * Q30_ONE) - longint'(s * s);
         c = longint'(root_floor(rem));
         roll = vector_angle(2 * (y * z + w * x), w * w - x * x - y * y + z * z);
         pitch = vector_angle(s, c);
         yaw = vector_angle(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
         e.gimbal_lock = 1'b0;
      end
      e.roll_angle = round_q412(roll);
      e.pitch_angle = round_q412(pitch);
      e.yaw_angle = round_q412(yaw);
      return e;
   endfunction

   // expected angles in order of acceptance
   class euler_scoreboard;
      q2e_pkg::euler_type pending_angles[$];
      int n_errors = 0;
      int n_checked = 0;
      int n_locked = 0;

      function void note_quat(q2e_pkg::quat_type q);
         pending_angles.insert(pending_angles.size(), predict_euler(q));
      endfunction

      function void check_euler(q2e_pkg::euler_type got);
         q2e_pkg::euler_type exp_e;
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            n_errors++;
            return;
         end
         exp_e = pending_angles.pop_front();
         n_checked++;
         if (got.gimbal_lock) n_locked++;
         if (got.roll_angle !== exp_e.roll_angle)
            $display("%0t: roll expected %0d actual %0d", $time,
                     exp_e.roll_angle, got.roll_angle);
         if (got.pitch_angle !== exp_e.pitch_angle)
            $display("%0t: pitch expected %0d actual %0d", $time,
                     exp_e.pitch_angle, got.pitch_angle);
         if (got.yaw_angle !== exp_e.yaw_angle)
            $display("%0t: yaw expected %0d actual %0d", $time,
                     exp_e.yaw_angle, got.yaw_angle);
         if (got.gimbal_lock !== exp_e.gimbal_lock)
            $display("%0t: lock expected %0b actual %0b", $time,
                     exp_e.gimbal_lock, got.gimbal_lock);
         if (got !== exp_e) n_errors++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   q2e_pkg::quat_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   q2e_pkg::euler_type rsp_data;

   euler_scoreboard board = new();
   q2e_pkg::quat_type quat_list[$];
   bit sending_done = 1'b0;
   bit hold_off_done = 1'b0;
   int idle_cycles = 0;

   always #4 clock = ~clock;

   quaternion_to_euler dut (.*);

   // accepted items and results, seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_quat(req_data);
         if (rsp_valid && !rsp_stall) board.check_euler(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic q2e_pkg::quat_type make_quat(int w, int x, int y, int z);
      q2e_pkg::quat_type q;
      q.quat_w = w[15:0]; q.quat_x = x[15:0]; q.quat_y = y[15:0]; q.quat_z = z[15:0];
      return q;
   endfunction

   function automatic void add_quat(q2e_pkg::quat_type q);
      quat_list.insert(quat_list.size(), q);
   endfunction

   function automatic logic [15:0] rand_part(int mode);
      unique case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 200)) - 16'd100;
         default: return 16'($urandom_range(0, 23170)) - 16'd11585;
      endcase
   endfunction

   // a quaternion: mostly small random components, some near gimbal lock, some raw noise
   function automatic q2e_pkg::quat_type random_quat();
      q2e_pkg::quat_type q;
      int kind;
      int a, b;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         q = 64'($urandom) << 32 | 64'($urandom);
      end else if (kind < 4) begin
         // w*y near +/- 0.5 with small x, z
         a = $urandom_range(22000, 24000);
         b = $urandom_range(22000, 24000);
         q = make_quat($urandom_range(0, 1) ? a : -a, int'($signed(rand_part(1))),
                       $urandom_range(0, 1) ? b : -b, int'($signed(rand_part(1))));
      end else begin
         q.quat_w = rand_part(2); q.quat_x = rand_part(2);
         q.quat_y = rand_part(2); q.quat_z = rand_part(2);
      end
      return q;
   endfunction

   // valid stays high between back-to-back items; dropped only for a pause
   task automatic send_quat(q2e_pkg::quat_type q, bit pause);
      int gap;
      gap = pause ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // sender
   initial begin
      int burst;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, axes, zero, gimbal lock both signs, saturation cases
      add_quat(make_quat(0, 0, 0, 0));
      add_quat(make_quat(32767, 0, 0, 0));
      add_quat(make_quat(-32768, 0, 0, 0));
      add_quat(make_quat(0, 32767, 0, 0));
      add_quat(make_quat(0, 0, 32767, 0));
      add_quat(make_quat(0, 0, 0, 32767));
      add_quat(make_quat(0, -32768, 0, 0));
      add_quat(make_quat(23170, 0, 23170, 0));
      add_quat(make_quat(23170, 0, -23170, 0));
      add_quat(make_quat(0, 23170, 0, 23170));
      add_quat(make_quat(0, 23170, 0, -23170));
      add_quat(make_quat(-23170, 100, 23170, -100));
      add_quat(make_quat(-32768, -32768, -32768, -32768));
      add_quat(make_quat(32767, 32767, 32767, 32767));
      add_quat(make_quat(32767, -32768, 32767, -32768));
      add_quat(make_quat(-32768, 32767, -32768, 32767));
      add_quat(make_quat(16384, 16384, 16384, 16384));
      add_quat(make_quat(-16384, 16384, 16384, -16384));
      add_quat(make_quat(0, 0, 0, 0) | 64'h0000_8000_0000_0001);
      add_quat(make_quat(22628, 0, 23170, 0));
      foreach (quat_list[i]) send_quat(quat_list[i], 1'b0);
      for (int i = 0; i < N_RANDOM; i++) begin
         burst = (i / 200) % 2;
         send_quat(random_quat(), burst == 1);
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver: random stalls, one long hold-off, stretches with none
   initial begin
      int wait_count;
      repeat (10) @(negedge clock);
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         @(negedge clock);
         if (!hold_off_done && board.n_checked >= 100) begin
            hold_off_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_valid && ((board.n_checked / 150) % 2 == 1)) begin
            wait_count = $urandom_range(0, 11);
            if (wait_count != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_count) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (sending_done);
      while (board.pending_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Checked %0d results, %0d in gimbal lock, directed and random quaternions",
               board.n_checked, board.n_locked);
      $display("with random stalls on both sides and one long result hold-off.");
      if (board.n_errors == 0 && board.pending_angles.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
